@@ sv/wts_pkg.sv @@
package wts_pkg;

    localparam int WTS_QUEUE_DEPTH = 32;

    localparam int ID_W   = 7;
    localparam int SEC_W  = 32;
    localparam int US_W   = 20;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 6;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 80;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEC_W-1:0] sec;
        logic [US_W-1:0]  us;
    } t_entry;

    // true when slot e wakes strictly later than (sec, us)
    function automatic logic later(input t_entry e, input logic [SEC_W-1:0] sec,
                                   input logic [US_W-1:0] us);
        if (e.sec != sec) begin
            return e.sec > sec;
        end
        return e.us > us;
    endfunction

endpackage

@@ sv/wake_time_sorted_queue.sv @@
// Sequence: insert scans down from the tail and moves each later entry up one slot;
//   pop and remove scan every occupied slot from the head; a refused insert or unused
//   command skips the scan. The head and second slots are then read; output stalls hold ST_OUT.
// Throughput: one request at a time; the next is taken the cycle after the result
//   enters the output register. The queue memory is scanned one slot a cycle.
// Reset (synchronous, active low) empties the queue and clears the output valid.
module wake_time_sorted_queue
    import wts_pkg::*;
#(
    parameter int QUEUE_DEPTH = WTS_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // thread_id [6:0], wake_seconds [38:7], wake_micros [58:39], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // command [1:0]
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // head_valid [0], head_id [7:1], head_seconds [39:8], head_micros [59:40],
    // second_valid [60], second_id [67:61], occupancy [73:68], zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [STAT_W-1:0]   m_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;   // downward scan, shift up, drop in
    localparam logic [2:0] ST_REM  = 3'd2;   // upward scan, shift down past match
    localparam logic [2:0] ST_RD0  = 3'd3;   // read head slot
    localparam logic [2:0] ST_RD1  = 3'd4;   // read second slot
    localparam logic [2:0] ST_OUT  = 3'd5;   // hand result to output register

    logic [2:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    t_entry              r_new, n_new;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_ptr, n_ptr;       // next slot to read (insert: slot + 1)
    logic                r_pv, n_pv;         // read data of r_pidx arrives this cycle
    logic [AW-1:0]       r_pidx, n_pidx;
    logic                r_found, n_found;
    logic [STAT_W-1:0]   r_status, n_status;
    t_entry              r_head, n_head;
    logic                r_m_valid, n_m_valid;
    logic [M_DATA_W-1:0] r_m_data, n_m_data;
    logic [STAT_W-1:0]   r_m_user, n_m_user;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, q;

    logic [AW:0]         pidx_inc;
    logic [AW-1:0]       pidx_dec;
    logic [CW-1:0]       ptr_dec;
    logic [OCC_W+CW-1:0] occ_ext;
    t_entry              head_out;
    logic [ID_W-1:0]     second_id;
    logic                load;

    wts_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    assign pidx_inc = {1'b0, r_pidx} + 1'b1;
    assign pidx_dec = r_pidx - 1'b1;
    assign ptr_dec  = r_ptr - 1'b1;
    assign occ_ext  = {{OCC_W{1'b0}}, r_cnt};

    // empty head and missing second read as zero
    assign head_out  = (r_cnt != '0) ? r_head : '0;
    assign second_id = (r_cnt > CW'(1)) ? q.id : '0;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_new     = r_new;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_pv      = r_pv;
        n_pidx    = r_pidx;
        n_found   = r_found;
        n_status  = r_status;
        n_head    = r_head;
        we        = 1'b0;
        waddr     = '0;
        wdata     = r_new;
        re        = 1'b0;
        raddr     = '0;
        load      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_cmd     = s_tuser;
                    n_new.id  = s_tdata[ID_W-1:0];
                    n_new.sec = s_tdata[ID_W+SEC_W-1:ID_W];
                    n_new.us  = s_tdata[ID_W+SEC_W+US_W-1:ID_W+SEC_W];
                    n_found   = 1'b0;
                    n_pv      = 1'b0;
                    n_status  = STAT_DONE;
                    case (s_tuser)
                        CMD_INSERT: begin
                            if (r_cnt >= CW'(QUEUE_DEPTH)) begin
                                n_status = STAT_FULL;
                                n_state  = ST_RD0;
                            end else begin
                                n_ptr   = r_cnt;
                                n_state = ST_INS;
                            end
                        end
                        CMD_POP, CMD_REMOVE: begin
                            n_ptr   = '0;
                            n_state = ST_REM;
                        end
                        default: begin
                            n_state = ST_RD0;
                        end
                    endcase
                end
            end

            ST_INS: begin
                // slots later than the new time move up one; first earlier or
                // equal slot stops the scan and the new entry goes above it
                if (r_pv) begin
                    we    = 1'b1;
                    waddr = pidx_inc[AW-1:0];
                    if (later(q, r_new.sec, r_new.us)) begin
                        wdata = q;
                    end else begin
                        n_state = ST_RD0;
                    end
                end else if (r_ptr == '0) begin
                    we      = 1'b1;
                    waddr   = '0;
                    n_state = ST_RD0;
                end
                if (n_state == ST_RD0) begin
                    n_cnt = r_cnt + 1'b1;
                    n_pv  = 1'b0;
                end else if (r_ptr != '0) begin
                    re     = 1'b1;
                    raddr  = ptr_dec[AW-1:0];
                    n_pidx = ptr_dec[AW-1:0];
                    n_ptr  = ptr_dec;
                    n_pv   = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
            end

            ST_REM: begin
                // behind the match every slot moves down one
                if (r_pv) begin
                    if (r_found) begin
                        we    = 1'b1;
                        waddr = pidx_dec;
                        wdata = q;
                    end else if (r_cmd == CMD_POP || q.id == r_new.id) begin
                        n_found = 1'b1;
                    end
                end
                if (r_ptr != r_cnt) begin
                    re     = 1'b1;
                    raddr  = r_ptr[AW-1:0];
                    n_pidx = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + 1'b1;
                    n_pv   = 1'b1;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        if (r_found) begin
                            n_cnt = r_cnt - 1'b1;
                        end else if (r_cmd == CMD_POP) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                        n_state = ST_RD0;
                    end
                end
            end

            ST_RD0: begin
                re      = 1'b1;
                raddr   = '0;
                n_state = ST_RD1;
            end

            ST_RD1: begin
                re      = 1'b1;
                raddr   = AW'(1);
                n_head  = q;
                n_state = ST_OUT;
            end

            ST_OUT: begin
                // second slot data stays on q until the output register frees
                if (!r_m_valid || m_tready) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid && !m_tready;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        if (load) begin
            n_m_valid = 1'b1;
            n_m_user  = r_status;
            n_m_data  = {{(M_DATA_W - 74){1'b0}},
                         occ_ext[OCC_W-1:0],
                         second_id,
                         (r_cnt > CW'(1)),
                         head_out.us,
                         head_out.sec,
                         head_out.id,
                         (r_cnt != '0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pv      <= n_pv;
            r_found   <= n_found;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_new    <= n_new;
        r_ptr    <= n_ptr;
        r_pidx   <= n_pidx;
        r_status <= n_status;
        r_head   <= n_head;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

endmodule

@@ sv/wts_ram.sv @@
module wts_ram
    import wts_pkg::*;
#(
    parameter int DEPTH = WTS_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
